// ----- hw/rtl/tpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tpq_pkg
// Types, sizes and codes shared by the ticket priority queue modules.
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 5;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_CHANGE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  prio;
    logic [10:0] minute;
    logic [15:0] arrival;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        req_type;
    logic [15:0] ticket_id;
    logic [1:0]  priority_req;
    logic [10:0] minute_stamp;
    logic [15:0] arrival_order;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic             head_valid;
    logic [15:0]      head_id;
    logic [POS_W-1:0] occupancy;
  } res_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SHDN_RD,
    S_SHDN_WR,
    S_PLACE,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_DONE
  } state_t;

  // true when a ranks strictly before b
  function automatic logic ranks_before(entry_t a, entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = (a.prio > b.prio);
    end else if (a.minute != b.minute) begin
      r = (a.minute < b.minute);
    end else begin
      r = (a.arrival < b.arrival);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/tpq_if.sv -----
// ----------------------------------------------------------------------------
// tpq_in_if / tpq_out_if
// Valid/ready channels for requests and results of the ticket queue.
// ----------------------------------------------------------------------------
interface tpq_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] ticket_id;
  logic [1:0]  priority_req;
  logic [10:0] minute_stamp;
  logic [15:0] arrival_order;

  modport source (output valid, req_type, ticket_id, priority_req, minute_stamp,
                  arrival_order, input ready);
  modport sink   (input valid, req_type, ticket_id, priority_req, minute_stamp,
                  arrival_order, output ready);
endinterface

interface tpq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  position;
  logic        head_valid;
  logic [15:0] head_id;
  logic [4:0]  occupancy;

  modport source (output valid, status, position, head_valid, head_id, occupancy,
                  input ready);
  modport sink   (input valid, status, position, head_valid, head_id, occupancy,
                  output ready);
endinterface

// ----- hw/rtl/tpq_ram.sv -----
// ----------------------------------------------------------------------------
// tpq_ram
// Generic simple dual-port RAM, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- hw/rtl/tpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpq_ctrl
// Sequencer: scans the entry RAM, shifts entries and places the new one.
// ----------------------------------------------------------------------------
module tpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  tpq_pkg::req_t     req,
  output logic              req_ready,
  output logic              res_valid,
  output tpq_pkg::res_t     res,
  input  logic              res_take,
  output tpq_pkg::ram_req_t ram_req,
  input  tpq_pkg::entry_t   ram_rdata
);

  tpq_pkg::state_t state_r, state_nxt;
  tpq_pkg::cnt_t   cnt_r, cnt_nxt;
  tpq_pkg::cnt_t   idx_r, idx_nxt;
  tpq_pkg::cnt_t   sh_r, sh_nxt;
  tpq_pkg::cnt_t   pos_r, pos_nxt;
  tpq_pkg::entry_t ent_r, ent_nxt;
  logic            kind_r, kind_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [15:0]     head_id_r, head_id_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    sh_r      <= sh_nxt;
    pos_r     <= pos_nxt;
    ent_r     <= ent_nxt;
    kind_r    <= kind_nxt;
    status_r  <= status_nxt;
    head_id_r <= head_id_nxt;
  end

  always_comb begin
    tpq_pkg::entry_t moved;

    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    sh_nxt      = sh_r;
    pos_nxt     = pos_r;
    ent_nxt     = ent_r;
    kind_nxt    = kind_r;
    status_nxt  = status_r;
    head_id_nxt = head_id_r;
    moved       = ram_rdata;
    moved.prio  = ent_r.prio;

    ram_req.we    = 1'b0;
    ram_req.waddr = tpq_pkg::addr_t'(sh_r);
    ram_req.wdata = ram_rdata;
    ram_req.raddr = tpq_pkg::addr_t'(idx_r);

    req_ready = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      tpq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ent_nxt.id      = req.ticket_id;
          ent_nxt.prio    = req.priority_req;
          ent_nxt.minute  = req.minute_stamp;
          ent_nxt.arrival = req.arrival_order;
          kind_nxt        = req.req_type;
          idx_nxt         = '0;
          pos_nxt         = '0;
          status_nxt      = tpq_pkg::ST_DONE;
          if (req.req_type == tpq_pkg::REQ_INSERT &&
              cnt_r == tpq_pkg::cnt_t'(tpq_pkg::DEPTH)) begin
            // drop the item
            status_nxt = tpq_pkg::ST_FULL;
            state_nxt  = tpq_pkg::S_HEAD_RD;
          end else begin
            state_nxt = tpq_pkg::S_SCAN_RD;
          end
        end
      end

      tpq_pkg::S_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          if (kind_r == tpq_pkg::REQ_INSERT) begin
            // beats none: goes to the tail
            pos_nxt   = cnt_r;
            sh_nxt    = cnt_r;
            state_nxt = tpq_pkg::S_SHDN_RD;
          end else begin
            status_nxt = tpq_pkg::ST_NOT_FOUND;
            pos_nxt    = '0;
            state_nxt  = tpq_pkg::S_HEAD_RD;
          end
        end else begin
          state_nxt = tpq_pkg::S_SCAN_CMP;
        end
      end

      tpq_pkg::S_SCAN_CMP: begin
        if (kind_r == tpq_pkg::REQ_INSERT) begin
          if (tpq_pkg::ranks_before(ent_r, ram_rdata)) begin
            pos_nxt   = idx_r;
            sh_nxt    = cnt_r;
            state_nxt = tpq_pkg::S_SHDN_RD;
          end else begin
            idx_nxt   = tpq_pkg::cnt_t'(idx_r + 1'b1);
            state_nxt = tpq_pkg::S_SCAN_RD;
          end
        end else begin
          if (ram_rdata.id == ent_r.id) begin
            // keep stamp and arrival, take the new priority
            ent_nxt   = moved;
            sh_nxt    = idx_r;
            state_nxt = tpq_pkg::S_SHUP_RD;
          end else begin
            idx_nxt   = tpq_pkg::cnt_t'(idx_r + 1'b1);
            state_nxt = tpq_pkg::S_SCAN_RD;
          end
        end
      end

      tpq_pkg::S_SHUP_RD: begin
        ram_req.raddr = tpq_pkg::addr_t'(sh_r + 1'b1);
        if (tpq_pkg::cnt_t'(sh_r + 1'b1) == cnt_r) begin
          // removal done: re-place as an insert
          cnt_nxt   = tpq_pkg::cnt_t'(cnt_r - 1'b1);
          kind_nxt  = tpq_pkg::REQ_INSERT;
          idx_nxt   = '0;
          state_nxt = tpq_pkg::S_SCAN_RD;
        end else begin
          state_nxt = tpq_pkg::S_SHUP_WR;
        end
      end

      tpq_pkg::S_SHUP_WR: begin
        ram_req.we = 1'b1;
        sh_nxt     = tpq_pkg::cnt_t'(sh_r + 1'b1);
        state_nxt  = tpq_pkg::S_SHUP_RD;
      end

      tpq_pkg::S_SHDN_RD: begin
        ram_req.raddr = tpq_pkg::addr_t'(sh_r - 1'b1);
        if (sh_r == pos_r) begin
          state_nxt = tpq_pkg::S_PLACE;
        end else begin
          state_nxt = tpq_pkg::S_SHDN_WR;
        end
      end

      tpq_pkg::S_SHDN_WR: begin
        ram_req.we = 1'b1;
        sh_nxt     = tpq_pkg::cnt_t'(sh_r - 1'b1);
        state_nxt  = tpq_pkg::S_SHDN_RD;
      end

      tpq_pkg::S_PLACE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = tpq_pkg::addr_t'(pos_r);
        ram_req.wdata = ent_r;
        cnt_nxt       = tpq_pkg::cnt_t'(cnt_r + 1'b1);
        state_nxt     = tpq_pkg::S_HEAD_RD;
      end

      tpq_pkg::S_HEAD_RD: begin
        ram_req.raddr = '0;
        state_nxt     = tpq_pkg::S_HEAD_WAIT;
      end

      tpq_pkg::S_HEAD_WAIT: begin
        head_id_nxt = ram_rdata.id;
        state_nxt   = tpq_pkg::S_DONE;
      end

      tpq_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = tpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tpq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status     = status_r;
    res.position   = tpq_pkg::POS_W'(pos_r);
    res.head_valid = (cnt_r != '0);
    res.head_id    = (cnt_r != '0) ? head_id_r : 16'd0;
    res.occupancy  = tpq_pkg::POS_W'(cnt_r);
  end

endmodule

// ----- hw/rtl/ticket_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// ticket_priority_queue_core
// Sorted ticket queue held in one entry RAM, with a registered result port.
// ----------------------------------------------------------------------------
// Requests enter on in_ch (insert, or change priority by id) and each gives
// exactly one result item on out_ch: status, position used, head and occupancy.
// Entries sit in a RAM sorted by priority, minute and arrival number. The
// sequencer reads entries one at a time through the registered RAM read.
// An insert scans to its position, shifts the later entries down one place
// and writes the new entry; at the tail nothing is shifted. A change scans
// for the id, shifts the later entries up to remove it, then runs the insert
// sequence on the rest. A miss scans all entries; a full insert reads the head.
// One item is worked on at a time; in_ch.ready is high only while idle.
// The result goes to an output register, so a new item is taken while a
// result still waits; a further result holds in the sequencer until taken.
// Reset (rst_n low, synchronous) empties the queue; RAM contents are not
// cleared, entries beyond the fill count are never used.
// ----------------------------------------------------------------------------
module ticket_priority_queue_core (
  input  logic      clk,
  input  logic      rst_n,
  tpq_in_if.sink    in_ch,
  tpq_out_if.source out_ch
);

  tpq_pkg::req_t     req;
  tpq_pkg::res_t     res;
  tpq_pkg::ram_req_t ram_req;
  tpq_pkg::entry_t   ram_rdata;
  logic              req_ready;
  logic              res_valid;
  logic              res_take;

  logic              out_valid_r;
  tpq_pkg::res_t     out_res_r;

  always_comb begin
    req.req_type      = in_ch.req_type;
    req.ticket_id     = in_ch.ticket_id;
    req.priority_req  = in_ch.priority_req;
    req.minute_stamp  = in_ch.minute_stamp;
    req.arrival_order = in_ch.arrival_order;
  end

  assign in_ch.ready = req_ready;

  tpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  tpq_ram #(
    .WIDTH (tpq_pkg::ENTRY_W),
    .DEPTH (tpq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // load when the output register is empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_res_r.status;
  assign out_ch.position   = out_res_r.position;
  assign out_ch.head_valid = out_res_r.head_valid;
  assign out_ch.head_id    = out_res_r.head_id;
  assign out_ch.occupancy  = out_res_r.occupancy;

endmodule
